// ===== sv/pks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_pkg: shared types and constants of the particle key/index sorter
// Holds the request and result payloads, the configuration register indexes,
// the sort modes and the command and status bundles between the two halves.
// ----------------------------------------------------------------------------
package pks_pkg;

   localparam int POS_W  = 24;
   localparam int LIFE_W = 32;
   localparam int KEY_W  = 52;
   localparam int SQ_W   = 50;
   localparam int IDX_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int MODE_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SORT_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_X    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_Y    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_Z    = 2'd3;

   localparam logic [MODE_W-1:0] MODE_LIFE_LEFT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AGE       = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [LIFE_W-1:0]       life_left;
      logic [LIFE_W-1:0]       life_initial;
      logic                    last_in;
   } pks_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] sorted_index;
      logic             last_out;
      logic             overflowed;
   } pks_rsp_type;

   typedef struct packed {
      logic load;
      logic square;
      logic key;
      logic insert;
      logic emit;
   } pks_cmd_type;

   typedef struct packed {
      logic last;
      logic one_left;
   } pks_sts_type;

endpackage

// ===== sv/pks_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_ctrl: sequencer of the particle key/index sorter
// Steps each request through squaring, key selection and insertion, and
// drives the emission of the sorted run after the final particle.
// ----------------------------------------------------------------------------
module pks_ctrl
   import pks_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  pks_sts_type sts,
   output pks_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_KEY    = 5'b00100,
      ST_INSERT = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_KEY;
         end
         ST_KEY: begin
            cmd.key  = 1'b1;
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = sts.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.one_left) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/pks_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_datapath: key computation and sorted cell row
// Computes the sort key, inserts it into a descending row of cells and
// shifts the arrival indices out of the head of the row during emission.
// ----------------------------------------------------------------------------
module pks_datapath
   import pks_pkg::*;
#(
   parameter int MAX_PARTICLES = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  pks_req_type           req_data,
   input  pks_cmd_type           cmd,
   output pks_sts_type           sts,
   output logic                  rsp_valid,
   output pks_rsp_type           rsp_data
);

   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

   logic [MODE_W-1:0]     mode_ff;
   logic signed [POS_W-1:0] view_x_ff, view_y_ff, view_z_ff;
   pks_req_type           req_ff;
   logic [SQ_W-1:0]       sq_x_ff, sq_y_ff, sq_z_ff;
   logic [MODE_W-1:0]     item_mode_ff;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [CNT_W-1:0]      count_ff;
   logic                  drop_ff;
   logic                  full;
   logic                  rsp_valid_ff;
   pks_rsp_type           rsp_ff;

   logic signed [POS_W:0]  dx, dy, dz;
   logic signed [SQ_W-1:0] px, py, pz;
   logic [LIFE_W:0]        age;

   logic [KEY_W-1:0] cell_key_ff [MAX_PARTICLES];
   logic [IDX_W-1:0] cell_idx_ff [MAX_PARTICLES];
   logic [KEY_W-1:0] key_prev [MAX_PARTICLES];
   logic [IDX_W-1:0] idx_prev [MAX_PARTICLES];
   logic [IDX_W-1:0] idx_next [MAX_PARTICLES];
   logic [MAX_PARTICLES-1:0] ge, ge_prev;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         view_x_ff <= '0;
         view_y_ff <= '0;
         view_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SORT_MODE: mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_VIEW_X:    view_x_ff <= csr_wdata;
            CSR_VIEW_Y:    view_y_ff <= csr_wdata;
            CSR_VIEW_Z:    view_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dx = {req_ff.pos_x[POS_W-1], req_ff.pos_x} - {view_x_ff[POS_W-1], view_x_ff};
   assign dy = {req_ff.pos_y[POS_W-1], req_ff.pos_y} - {view_y_ff[POS_W-1], view_y_ff};
   assign dz = {req_ff.pos_z[POS_W-1], req_ff.pos_z} - {view_z_ff[POS_W-1], view_z_ff};
   assign px = dx * dx;
   assign py = dy * dy;
   assign pz = dz * dz;
   assign age = {1'b0, req_ff.life_initial} + {1'b1, {LIFE_W{1'b0}}}
                - {1'b0, req_ff.life_left};

   always_comb begin
      case (item_mode_ff)
         MODE_LIFE_LEFT: key_in = KEY_W'(req_ff.life_left);
         MODE_AGE:       key_in = KEY_W'(age);
         default:        key_in = KEY_W'(sq_x_ff) + KEY_W'(sq_y_ff) + KEY_W'(sq_z_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff       <= req_data;
         item_mode_ff <= mode_ff;
      end
      if (cmd.square) begin
         sq_x_ff <= SQ_W'(px);
         sq_y_ff <= SQ_W'(py);
         sq_z_ff <= SQ_W'(pz);
      end
      if (cmd.key) key_ff <= key_in;
   end

   assign full = (count_ff == CNT_W'(MAX_PARTICLES));

   always_comb begin
      for (int i = 0; i < MAX_PARTICLES; i++) begin
         ge[i] = (CNT_W'(i) < count_ff) && (cell_key_ff[i] >= key_ff);
      end
   end
   assign ge_prev = {ge[MAX_PARTICLES-2:0], 1'b1};

   for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign key_prev[i] = '0;
         assign idx_prev[i] = '0;
      end else begin : g_body
         assign key_prev[i] = cell_key_ff[i-1];
         assign idx_prev[i] = cell_idx_ff[i-1];
      end
      if (i == MAX_PARTICLES - 1) begin : g_tail
         assign idx_next[i] = '0;
      end else begin : g_inner
         assign idx_next[i] = cell_idx_ff[i+1];
      end

      always_ff @(posedge clock) begin
         if (cmd.insert && !full && !ge[i]) begin
            if (ge_prev[i]) begin
               cell_key_ff[i] <= key_ff;
               cell_idx_ff[i] <= IDX_W'(count_ff);
            end else begin
               cell_key_ff[i] <= key_prev[i];
               cell_idx_ff[i] <= idx_prev[i];
            end
         end else if (cmd.emit) begin
            cell_idx_ff[i] <= idx_next[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
         if (cmd.insert) begin
            if (full) drop_ff <= 1'b1;
            else count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.emit) begin
            count_ff <= count_ff - CNT_W'(1);
            if (sts.one_left) drop_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.sorted_index <= cell_idx_ff[0];
         rsp_ff.last_out     <= sts.one_left;
         rsp_ff.overflowed   <= drop_ff;
      end
   end

   assign sts.last     = req_ff.last_in;
   assign sts.one_left = (count_ff == CNT_W'(1));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

// ===== sv/particle_key_index_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_key_index_sort: descending key/index sorter for particles
// Takes particles one request at a time and emits their arrival indices in
// descending key order after the request marked last.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request keeps
// busy high through its register stages: difference squaring, key selection
// and insertion into the sorted row of cells, so the next request is taken
// only after the previous one is inserted. On the request marked last, the
// stored indices follow one per cycle on rsp_data, each marked by a
// one-cycle rsp_valid strobe, the first one once the insertion is done and
// the head index is registered; busy stays high until the final index has
// left the head of the row. The receiver cannot stall the results. Equal
// keys leave lower arrival index first. Particles beyond MAX_PARTICLES are
// dropped and overflowed is set on every result of that set. The user must
// write configuration through csr_we, csr_index and csr_wdata while busy is
// low; the block does not enforce this. Reset clears the configuration, the
// fill count and the drop flag; the row of cells needs no clearing.
// ----------------------------------------------------------------------------
module particle_key_index_sort
   import pks_pkg::*;
#(
   parameter int MAX_PARTICLES = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pks_req_type           req_data,
   output logic                  rsp_valid,
   output pks_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pks_cmd_type cmd;
   pks_sts_type sts;

   pks_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   pks_datapath #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/pks_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_checker: port-level checks of the particle key/index sorter
// Watches the request and result ports for the busy handshake and the framing of the sorted run.
// ----------------------------------------------------------------------------
module pks_checker
   import pks_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input pks_rsp_type rsp_data
);

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a request was taken");

   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_out |=> rsp_valid)
      else $error("gap in the sorted run");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_out |=> !rsp_valid)
      else $error("result after the end of the run");

   a_run_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("run started while idle");

endmodule

bind particle_key_index_sort pks_checker u_pks_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== dv/particle_key_index_sort_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_key_index_sort_tb: self-checking bench for the particle sorter
// A short table of directed sets is followed by random sets of particles with
// random content, random sort modes and view points. The sets include ties,
// negative ages, the unused mode and sets that overflow the buffer. Every
// emitted index is checked against a sorted copy of the keys kept here.
// ----------------------------------------------------------------------------
module particle_key_index_sort_tb;
   import pks_pkg::*;

   localparam int CAPACITY   = 64;
   localparam int IDLE_WAIT  = 8;
   localparam int CYCLE_CAP  = 400000;
   localparam int ITEM_GOAL  = 100;

   typedef struct {
      bit                    cfg;
      logic [MODE_W-1:0]     mode;
      logic [CSR_DATA_W-1:0] view;
      pks_req_type           req;
      bit                    typed;
      logic [IDX_W-1:0]      t_index;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   pks_req_type           req_data;
   logic                  rsp_valid;
   pks_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic [MODE_W-1:0]     cur_mode;
   logic [POS_W-1:0]      cur_view [3];
   logic [KEY_W-1:0]      key_row [CAPACITY];
   logic [IDX_W-1:0]      idx_row [CAPACITY];
   int unsigned           fill;
   bit                    dropped;
   pks_rsp_type           rank_q [$];

   dir_row_type           dir_tab [$];
   int unsigned           errors;
   int unsigned           cycles;
   int unsigned           n_items;
   int unsigned           n_results;
   int unsigned           n_sets;
   int unsigned           n_overflow_sets;

   particle_key_index_sort u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [KEY_W-1:0] particle_key(pks_req_type r);
      longint d;
      longint acc;
      acc = 0;
      case (cur_mode)
         MODE_LIFE_LEFT: return KEY_W'(r.life_left);
         MODE_AGE: return KEY_W'(longint'(r.life_initial) - longint'(r.life_left)
                                 + 64'h1_0000_0000);
         default: begin
            d = longint'(r.pos_x) - longint'($signed(cur_view[0]));
            acc += d * d;
            d = longint'(r.pos_y) - longint'($signed(cur_view[1]));
            acc += d * d;
            d = longint'(r.pos_z) - longint'($signed(cur_view[2]));
            acc += d * d;
            return KEY_W'(acc);
         end
      endcase
   endfunction

   // Inserts the particle into the sorted copy, or marks the set dropped when full;
   // on the last request the ranked indices are returned in emission order.
   task automatic rank_particle(pks_req_type r, output pks_rsp_type ranked [$]);
      logic [KEY_W-1:0] k;
      int               p;
      pks_rsp_type      e;
      ranked = {};
      if (fill < CAPACITY) begin
         k = particle_key(r);
         p = fill;
         while (p > 0 && key_row[p-1] < k) begin
            key_row[p] = key_row[p-1];
            idx_row[p] = idx_row[p-1];
            p--;
         end
         key_row[p] = k;
         idx_row[p] = IDX_W'(fill);
         fill++;
      end else begin
         dropped = 1'b1;
      end
      if (r.last_in) begin
         for (int i = 0; i < fill; i++) begin
            e.sorted_index = idx_row[i];
            e.last_out     = (i == fill - 1);
            e.overflowed   = dropped;
            ranked = {ranked, e};
         end
         if (dropped)
            n_overflow_sets++;
         n_sets++;
         fill    = 0;
         dropped = 1'b0;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (rank_q.size() != 0)
         @(posedge clock);
      while (busy)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SORT_MODE: cur_mode    = val[MODE_W-1:0];
         CSR_VIEW_X:    cur_view[0] = val;
         CSR_VIEW_Y:    cur_view[1] = val;
         CSR_VIEW_Z:    cur_view[2] = val;
      endcase
   endtask

   task automatic configure(logic [MODE_W-1:0] m, logic [CSR_DATA_W-1:0] vx,
                            logic [CSR_DATA_W-1:0] vy, logic [CSR_DATA_W-1:0] vz);
      wait_idle();
      csr_write(CSR_SORT_MODE, CSR_DATA_W'(m));
      csr_write(CSR_VIEW_X, vx);
      csr_write(CSR_VIEW_Y, vy);
      csr_write(CSR_VIEW_Z, vz);
   endtask

   // Drives one request, waits for it to be taken and queues what it causes.
   task automatic send_request(pks_req_type r, bit typed, logic [IDX_W-1:0] t_index);
      pks_rsp_type ranked [$];
      pks_rsp_type e;
      int unsigned gap;
      int unsigned pick;
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      n_items++;
      rank_particle(r, ranked);
      if (typed) begin
         e.sorted_index = t_index;
         e.last_out     = 1'b1;
         e.overflowed   = 1'b0;
         rank_q = {rank_q, e};
      end else begin
         rank_q = {rank_q, ranked};
      end
      pick = $urandom_range(0, 19);
      gap  = (pick < 12) ? 0 : (pick < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic pks_req_type make_req(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                            logic [POS_W-1:0] z, logic [LIFE_W-1:0] left,
                                            logic [LIFE_W-1:0] init, bit last);
      pks_req_type r;
      r.pos_x        = x;
      r.pos_y        = y;
      r.pos_z        = z;
      r.life_left    = left;
      r.life_initial = init;
      r.last_in      = last;
      return r;
   endfunction

   function automatic dir_row_type make_row(bit cfg, logic [MODE_W-1:0] m,
                                            logic [CSR_DATA_W-1:0] v, pks_req_type r,
                                            bit typed, logic [IDX_W-1:0] t_index);
      dir_row_type d;
      d.cfg     = cfg;
      d.mode    = m;
      d.view    = v;
      d.req     = r;
      d.typed   = typed;
      d.t_index = t_index;
      return d;
   endfunction

   function automatic void add_row(dir_row_type d);
      dir_tab = {dir_tab, d};
   endfunction

   function automatic pks_req_type random_req(bit last);
      pks_req_type r;
      r = make_req(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   LIFE_W'($urandom), LIFE_W'($urandom), last);
      if ($urandom_range(0, 3) == 0) begin
         r.life_left    = LIFE_W'($urandom_range(0, 3));
         r.life_initial = LIFE_W'($urandom_range(0, 3));
         r.pos_x        = POS_W'($urandom_range(0, 1));
         r.pos_y        = '0;
         r.pos_z        = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pks_rsp_type e;
      if (!reset && rsp_valid) begin
         n_results++;
         if (rank_q.size() == 0) begin
            $error("unexpected result: sorted_index %0d", rsp_data.sorted_index);
            errors++;
         end else begin
            e = rank_q.pop_front();
            if (rsp_data.sorted_index !== e.sorted_index) begin
               $error("sorted_index: expected %0d, got %0d", e.sorted_index,
                      rsp_data.sorted_index);
               errors++;
            end
            if (rsp_data.last_out !== e.last_out) begin
               $error("last_out: expected %0d, got %0d", e.last_out, rsp_data.last_out);
               errors++;
            end
            if (rsp_data.overflowed !== e.overflowed) begin
               $error("overflowed: expected %0d, got %0d", e.overflowed,
                      rsp_data.overflowed);
               errors++;
            end
         end
      end
   end

   initial begin
      localparam logic [POS_W-1:0]  P_MAX = 24'h7F_FFFF;
      localparam logic [POS_W-1:0]  P_MIN = 24'h80_0000;
      localparam logic [LIFE_W-1:0] L_MAX = 32'hFFFF_FFFF;
      int unsigned set_len;
      int unsigned pick;
      int unsigned round_no;
      logic [MODE_W-1:0] m;
      pks_req_type r;

      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      cur_mode  = '0;
      cur_view  = '{default: '0};
      fill      = 0;
      dropped   = 1'b0;
      round_no  = 0;

      add_row(make_row(1, 0, 0, make_req(0, 0, 0, 0, 0, 1), 1, 0));
      add_row(make_row(1, 0, P_MAX, make_req(P_MAX, P_MAX, P_MAX, 0, 0, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(P_MIN, P_MIN, P_MIN, 0, 0, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(0, 0, 0, 0, 0, 1), 0, 0));
      add_row(make_row(1, 0, P_MIN, make_req(P_MAX, P_MAX, P_MAX, 0, 0, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(5, 5, 5, 0, 0, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(5, 5, 5, 0, 0, 1), 0, 0));
      add_row(make_row(1, MODE_LIFE_LEFT, 0, make_req(0, 0, 0, 0, 0, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(0, 0, 0, L_MAX, 0, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(0, 0, 0, L_MAX, 0, 1), 0, 0));
      add_row(make_row(1, MODE_AGE, 0, make_req(0, 0, 0, L_MAX, 0, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(0, 0, 0, 0, L_MAX, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(0, 0, 0, 7, 7, 1), 0, 0));
      add_row(make_row(1, 3, 24'h00_0100, make_req(1, 2, 3, 9, 1, 0), 0, 0));
      add_row(make_row(0, 0, 0, make_req(P_MIN, 0, P_MAX, 1, 9, 1), 0, 0));
      add_row(make_row(1, MODE_LIFE_LEFT, 0, make_req(0, 0, 0, L_MAX, L_MAX, 1), 1, 0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].cfg)
            configure(dir_tab[i].mode, dir_tab[i].view, dir_tab[i].view, dir_tab[i].view);
         send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].t_index);
      end

      while (n_items < ITEM_GOAL) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)
            configure('0, P_MAX, P_MIN, CSR_DATA_W'($urandom));
         else if (pick < 8)
            configure(MODE_W'($urandom_range(0, 3)), CSR_DATA_W'($urandom),
                      CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         pick = $urandom_range(0, 19);
         if (round_no == 0)
            set_len = CAPACITY + 1;
         else
            set_len = (pick < 15) ? $urandom_range(1, 8) : $urandom_range(9, 16);
         round_no++;
         for (int i = 0; i < set_len; i++) begin
            if (i > 0 && $urandom_range(0, 19) == 0) begin
               m = MODE_W'($urandom_range(0, 3));
               wait_idle();
               csr_write(CSR_SORT_MODE, CSR_DATA_W'(m));
            end
            r = random_req(i == set_len - 1);
            send_request(r, 0, 0);
         end
      end

      @(negedge clock);
      start = 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);

      $display("Sent %0d particles in %0d sets, %0d of them overflowing the buffer.",
               n_items, n_sets, n_overflow_sets);
      $display("Checked %0d sorted indices across all four sort modes.", n_results);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
